@@ rtl/ktd_pkg.sv @@
package ktd_pkg;

	// Default alphabet size and the ASCII codes the block works with.
	localparam int unsigned AlphabetSizeDef = 26;
	localparam logic [7:0]  CharA           = 8'd65;
	localparam logic [7:0]  CharSpace       = 8'd32;

	// Request commands.
	typedef enum logic [1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_ADD     = 2'd1,
		CMD_BUILD   = 2'd2,
		CMD_DECRYPT = 2'd3
	} cmd_t;

	// Build sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_HEAD,
		ST_HEAD_WR,
		ST_COL_RD,
		ST_COL_WR
	} state_t;

endpackage

@@ rtl/ktd_if.sv @@
// Request channel: one command with its symbol.
interface ktd_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] symbol;

	modport source (output valid, output command, output symbol, input ready);
	modport sink   (input valid, input command, input symbol, output ready);
endinterface

// Result channel: one decrypted character with its error flag.
interface ktd_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] plain_char;
	logic       bad_char;

	modport source (output valid, output plain_char, output bad_char, input ready);
	modport sink   (input valid, input plain_char, input bad_char, output ready);
endinterface

@@ rtl/keyword_transposition_decrypt_core.sv @@
// Decrypt requests: one per cycle while the sequencer is idle and the result is taken, result
// in the cycle after acceptance, read from inverse_mem. Clear, add and empty-keyword build requests give no result.
// Any other build stalls requests: one sweep of the alphabet to collect unused letters,
// then a look at each letter for heads, and a write for each key position.
// Reset (arst_n low, asynchronous) empties the keyword and marks the table as identity;
// no clearing pass is needed, since the identity flag stands in for the table until a build.
module keyword_transposition_decrypt_core #(
	parameter int unsigned ALPHABET_SIZE = ktd_pkg::AlphabetSizeDef
) (
	input  logic      clk,
	input  logic      arst_n,
	ktd_req_if.sink   req,
	ktd_res_if.source res
);
	import ktd_pkg::*;

	// Width of a letter index or key position, of a count up to the alphabet size,
	// and of a column cursor, which can run past the unused count by one stride.
	localparam int unsigned IdxW = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;
	localparam int unsigned CntW = $clog2(ALPHABET_SIZE + 1);
	localparam int unsigned DW   = $clog2(2 * ALPHABET_SIZE);
	localparam logic [CntW-1:0] LastLetter = CntW'(ALPHABET_SIZE - 1);
	localparam logic [CntW-1:0] AlphaCnt   = CntW'(ALPHABET_SIZE);

	state_t state_q, state_d;

	// Keyword state. The position of each keyword letter in first-seen order is kept
	// in kwpos_mem, addressed by the letter, which is what the build needs to find
	// the column that hangs under a head letter.
	logic [ALPHABET_SIZE-1:0] seen_q;
	logic [CntW-1:0]          len_q;
	logic                     built_q;

	// Build sequencer registers.
	logic [CntW-1:0] letter_q;   // alphabet sweep, later the head letter
	logic [CntW-1:0] nunused_q;  // number of unused letters collected
	logic [CntW-1:0] pos_q;      // next key position to hand out
	logic [DW-1:0]   col_q;      // cursor into unused_mem for the current column

	// Memories, each with a registered read port.
	logic [IdxW-1:0] kwpos_mem   [ALPHABET_SIZE];
	logic [IdxW-1:0] unused_mem  [ALPHABET_SIZE];
	logic [IdxW-1:0] inverse_mem [ALPHABET_SIZE];
	logic [IdxW-1:0] kwpos_rd_q;
	logic [IdxW-1:0] unused_rd_q;

	// Decrypt stage: the table read issued at acceptance lands here in the next cycle.
	logic            valid_s1;
	logic [7:0]      sym_s1;
	logic            letter_s1;
	logic [IdxW-1:0] inv_rd_s1;

	// Request decoding.
	logic [7:0]      sym_off;
	logic            is_letter;
	logic [IdxW-1:0] idx;
	logic            in_ready;
	logic            in_fire;
	cmd_t            cmd;

	assign cmd       = cmd_t'(req.command);
	assign sym_off   = req.symbol - CharA;
	assign is_letter = (req.symbol >= CharA) && (sym_off < 8'(ALPHABET_SIZE));
	assign idx       = sym_off[IdxW-1:0];
	assign in_fire   = req.valid && in_ready;

	// Sequencer control for the cycle.
	logic head_seen;
	logic col_more;
	logic fill_wr;
	logic add_ok;

	assign head_seen = seen_q[letter_q[IdxW-1:0]];
	assign col_more  = col_q < DW'(nunused_q);
	assign fill_wr   = !seen_q[letter_q[IdxW-1:0]];
	assign add_ok    = is_letter && !seen_q[idx] && (len_q < AlphaCnt);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && cmd == CMD_BUILD && len_q != '0) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				if (letter_q == LastLetter) begin
					state_d = ST_HEAD;
				end
			end
			ST_HEAD: begin
				if (head_seen) begin
					state_d = ST_HEAD_WR;
				end else if (letter_q == LastLetter) begin
					state_d = ST_IDLE;
				end
			end
			ST_HEAD_WR: state_d = ST_COL_RD;
			ST_COL_RD: begin
				if (col_more) begin
					state_d = ST_COL_WR;
				end else if (letter_q == LastLetter) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_HEAD;
				end
			end
			ST_COL_WR: state_d = ST_COL_RD;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: requests are taken only when it is idle and the
	// result stage is empty or being drained in the same cycle.
	always_comb begin
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = !valid_s1 || res.ready;
			default: in_ready = 1'b0;
		endcase
	end

	assign req.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Keyword, identity flag and sequencer counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= '0;
			len_q     <= '0;
			built_q   <= 1'b0;
			letter_q  <= '0;
			nunused_q <= '0;
			pos_q     <= '0;
			col_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (cmd)
							CMD_CLEAR: begin
								seen_q <= '0;
								len_q  <= '0;
							end
							CMD_ADD: begin
								if (add_ok) begin
									seen_q[idx] <= 1'b1;
									len_q       <= len_q + 1'b1;
								end
							end
							CMD_BUILD: begin
								// An empty keyword yields the plain alphabet as key.
								if (len_q == '0) begin
									built_q <= 1'b0;
								end
								letter_q  <= '0;
								nunused_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_FILL: begin
					if (fill_wr) begin
						nunused_q <= nunused_q + 1'b1;
					end
					if (letter_q == LastLetter) begin
						letter_q <= '0;
						pos_q    <= '0;
						built_q  <= 1'b1;
					end else begin
						letter_q <= letter_q + 1'b1;
					end
				end
				ST_HEAD: begin
					if (!head_seen) begin
						letter_q <= letter_q + 1'b1;
					end
				end
				ST_HEAD_WR: begin
					pos_q <= pos_q + 1'b1;
					col_q <= DW'(kwpos_rd_q);
				end
				ST_COL_RD: begin
					if (col_more) begin
						col_q <= col_q + DW'(len_q);
					end else begin
						letter_q <= letter_q + 1'b1;
					end
				end
				ST_COL_WR: begin
					pos_q <= pos_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Keyword position memory: written on add, read for each head letter.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_fire && cmd == CMD_ADD && add_ok) begin
			kwpos_mem[idx] <= len_q[IdxW-1:0];
		end
		if (state_q == ST_HEAD && head_seen) begin
			kwpos_rd_q <= kwpos_mem[letter_q[IdxW-1:0]];
		end
	end

	// Unused letters in alphabet order: written by the fill sweep, read down a column.
	always_ff @(posedge clk) begin
		if (state_q == ST_FILL && fill_wr) begin
			unused_mem[nunused_q[IdxW-1:0]] <= letter_q[IdxW-1:0];
		end
		if (state_q == ST_COL_RD && col_more) begin
			unused_rd_q <= unused_mem[col_q[IdxW-1:0]];
		end
	end

	// Inverse key: a head letter takes the next position, then each letter of its column.
	always_ff @(posedge clk) begin
		if (state_q == ST_HEAD_WR) begin
			inverse_mem[letter_q[IdxW-1:0]] <= pos_q[IdxW-1:0];
		end else if (state_q == ST_COL_WR) begin
			inverse_mem[unused_rd_q] <= pos_q[IdxW-1:0];
		end
		if (in_fire && cmd == CMD_DECRYPT && is_letter) begin
			inv_rd_s1 <= inverse_mem[idx];
		end
	end

	// Result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= (cmd == CMD_DECRYPT);
		end else if (res.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && cmd == CMD_DECRYPT) begin
			sym_s1    <= req.symbol;
			letter_s1 <= is_letter;
		end
	end

	// Before a build the table is the identity, so a letter decrypts to itself.
	assign res.valid      = valid_s1;
	assign res.plain_char = (letter_s1 && built_q) ? (CharA + 8'(inv_rd_s1)) : sym_s1;
	assign res.bad_char   = !letter_s1 && (sym_s1 != CharSpace);

endmodule
